// ===== design/log_token_sequence_value_filter_unit_macros.svh =====
// Assertion macros shared by the token filter checker.
`ifndef LOG_TOKEN_SEQUENCE_VALUE_FILTER_UNIT_MACROS_SVH
`define LOG_TOKEN_SEQUENCE_VALUE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LTSVF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LTSVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ltsvf_pkg.sv =====
// Package: constants, phase codes and keyword lookup for the token filter.
package ltsvf_pkg;

    localparam int DIGIT_WINDOW_DEF = 6;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int VALUE_W  = 20;
    localparam int CHAR_W   = 8;
    localparam int TOKLEN_W = 4;

    localparam logic [CHAR_W-1:0]   SPACE_BYTE      = 8'd32;
    localparam logic [CHAR_W-1:0]   DIGIT_ZERO      = 8'h30;
    localparam logic [VALUE_W-1:0]  THRESHOLD_RESET = 20'd1500;
    localparam logic [TOKLEN_W-1:0] LEN_MAX         = 4'd15;

    // search phase codes
    localparam logic [1:0] PH_WORD0  = 2'd0;  // waiting for "counter"
    localparam logic [1:0] PH_DASH   = 2'd1;  // waiting for "-"
    localparam logic [1:0] PH_WORD2  = 2'd2;  // waiting for "counter1"
    localparam logic [1:0] PH_WINDOW = 2'd3;  // collecting digit window

    function automatic logic [TOKLEN_W-1:0] word_len(input logic [1:0] ph);
        logic [TOKLEN_W-1:0] len;
        case (ph)
            PH_WORD0: len = 4'd7;
            PH_DASH:  len = 4'd1;
            default:  len = 4'd8;
        endcase
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] word_char(input logic [1:0] ph,
                                                   input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = "c";
            3'd1:    ch = "o";
            3'd2:    ch = "u";
            3'd3:    ch = "n";
            3'd4:    ch = "t";
            3'd5:    ch = "e";
            3'd6:    ch = "r";
            default: ch = "1";
        endcase
        if (ph == PH_DASH) begin
            ch = "-";
        end
        return ch;
    endfunction

endpackage

// ===== design/log_token_sequence_value_filter_unit.sv =====
// Top level: token sequence matcher with digit window value filter.
//
// Usage
//   Input channel (i_valid / o_ready / i_char_in) takes one text byte per
//   item. Tokens end only at a space. After the token sequence "counter",
//   "-", "counter1" the next DIGIT_WINDOW bytes form a window whose decimal
//   digits are read as a number; a value above the threshold bumps a
//   saturating hit counter.
//   Output channel (o_valid / i_ready) gives exactly one result item per
//   input item, in order: value_valid, value, over_threshold, hit_count.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   threshold; it is always ready and should be written only while idle.
// Timing
//   Results are registered (skid register while one waits). Throughput is
//   one item per cycle while o_ready is high; all per-byte work is one
//   compare, one multiply-by-ten add and one 20-bit compare.
// Stall and reset
//   A two-entry output stage (result register plus skid register) lets a
//   byte be taken while a result waits; o_ready drops only when both hold
//   results. Reset (synchronous, active low) empties the output stage,
//   restarts the search, clears the hit count and sets the threshold to 1500.
module log_token_sequence_value_filter_unit #(
    parameter int DIGIT_WINDOW = ltsvf_pkg::DIGIT_WINDOW_DEF,
    parameter int COUNT_WIDTH  = ltsvf_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ltsvf_pkg::CHAR_W-1:0]    i_char_in,
    // threshold write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ltsvf_pkg::VALUE_W-1:0]   i_cfg_data,
    // results
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_value_valid,
    output logic [ltsvf_pkg::VALUE_W-1:0]   o_value,
    output logic                            o_over_threshold,
    output logic [COUNT_WIDTH-1:0]          o_hit_count
);
    import ltsvf_pkg::*;

    localparam int WL_W = $clog2(DIGIT_WINDOW + 1);
    localparam logic [WL_W-1:0] WL_START = WL_W'(DIGIT_WINDOW);

    typedef struct packed {
        logic                   value_valid;
        logic [VALUE_W-1:0]     value;
        logic                   over;
        logic [COUNT_WIDTH-1:0] hits;
    } t_result;

    // search state
    logic [VALUE_W-1:0]     r_threshold;
    logic [1:0]             r_phase,     n_phase;
    logic [TOKLEN_W-1:0]    r_tok_len,   n_tok_len;
    logic                   r_tok_match, n_tok_match;
    logic [WL_W-1:0]        r_win_left,  n_win_left;
    logic [VALUE_W-1:0]     r_acc,       n_acc;
    logic [COUNT_WIDTH-1:0] r_hits,      n_hits;

    // output stage
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic accept_in;
    logic take_out;
    logic is_digit;
    logic tok_hit;
    logic [VALUE_W-1:0] acc_step;

    assign o_ready     = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign accept_in   = i_valid && o_ready;
    assign take_out    = r_out_valid && i_ready;

    assign is_digit = i_char_in inside {["0":"9"]};
    assign acc_step = VALUE_W'((r_acc << 3) + (r_acc << 1)
                               + VALUE_W'(i_char_in - DIGIT_ZERO));
    assign tok_hit  = r_tok_match && (r_tok_len == word_len(r_phase));

    always_comb begin
        n_phase     = r_phase;
        n_tok_len   = r_tok_len;
        n_tok_match = r_tok_match;
        n_win_left  = r_win_left;
        n_acc       = r_acc;
        n_hits      = r_hits;
        n_res       = '0;

        if (r_phase == PH_WINDOW) begin
            if (is_digit) begin
                n_acc = acc_step;
            end
            if (r_win_left != '0) begin
                n_win_left = r_win_left - 1'b1;
            end
            if (n_win_left == '0) begin
                // window closed: report and restart the search
                n_res.value_valid = 1'b1;
                n_res.value       = n_acc;
                if (n_acc > r_threshold) begin
                    n_res.over = 1'b1;
                    if (r_hits != '1) begin
                        n_hits = r_hits + 1'b1;
                    end
                end
                n_acc       = '0;
                n_phase     = PH_WORD0;
                n_tok_len   = '0;
                n_tok_match = 1'b1;
            end
        end else if (i_char_in == SPACE_BYTE) begin
            if (tok_hit) begin
                if (r_phase == PH_WORD2) begin
                    n_phase    = PH_WINDOW;
                    n_win_left = WL_START;
                    n_acc      = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            n_tok_len   = '0;
            n_tok_match = 1'b1;
        end else begin
            // past the word's end, or wrong byte at this position
            if (r_tok_len >= word_len(r_phase) ||
                word_char(r_phase, r_tok_len[2:0]) != i_char_in) begin
                n_tok_match = 1'b0;
            end
            if (r_tok_len != LEN_MAX) begin
                n_tok_len = r_tok_len + 1'b1;
            end
        end
        n_res.hits = n_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WORD0;
            r_tok_len   <= '0;
            r_tok_match <= 1'b1;
            r_win_left  <= '0;
            r_acc       <= '0;
            r_hits      <= '0;
        end else if (accept_in) begin
            r_phase     <= n_phase;
            r_tok_len   <= n_tok_len;
            r_tok_match <= n_tok_match;
            r_win_left  <= n_win_left;
            r_acc       <= n_acc;
            r_hits      <= n_hits;
        end
    end

    // result register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept_in;
            end
        end else if (accept_in) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept_in) begin
                r_out <= n_res;
            end
        end else if (accept_in) begin
            if (r_out_valid) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value_valid    = r_out.value_valid;
    assign o_value          = r_out.value;
    assign o_over_threshold = r_out.over;
    assign o_hit_count      = r_out.hits;

endmodule

// ===== design/ltsvf_checker.sv =====
// Port-level checker for the token filter, bound to the top level.
`include "log_token_sequence_value_filter_unit_macros.svh"

module ltsvf_checker #(
    parameter int COUNT_WIDTH = ltsvf_pkg::COUNT_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_value_valid,
    input logic [ltsvf_pkg::VALUE_W-1:0] o_value,
    input logic                          o_over_threshold,
    input logic [COUNT_WIDTH-1:0]        o_hit_count
);

    // stalled result holds
    `LTSVF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_value) && $stable(o_hit_count), "result changed while stalled")

    `LTSVF_ASSERT_NOW(a_over_needs_valid, i_clk, i_rst_n, o_valid && o_over_threshold,
        o_value_valid, "over_threshold without value_valid")

    `LTSVF_ASSERT_NOW(a_value_zero, i_clk, i_rst_n, o_valid && !o_value_valid,
        o_value == '0, "value nonzero outside a window result")

    // hit count never goes down from one result to the next
    `LTSVF_ASSERT_NEXT(a_hits_monotonic, i_clk, i_rst_n, o_valid && i_ready,
        !o_valid || o_hit_count >= $past(o_hit_count), "hit count decreased")

endmodule

bind log_token_sequence_value_filter_unit ltsvf_checker #(
    .COUNT_WIDTH(COUNT_WIDTH)
) u_ltsvf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_value_valid   (o_value_valid),
    .o_value         (o_value),
    .o_over_threshold(o_over_threshold),
    .o_hit_count     (o_hit_count)
);
